>>> sv/egsa_pkg.sv
// Shared codes, constants and controller/datapath interface types for the gradient scatter-add.
package egsa_pkg;

  // Command codes carried in s_tuser.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes carried in m_tuser.
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_ROW = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;
  localparam logic [1:0] STAT_COL = 2'd3;

  // Register indexes on the configuration port (taken from paddr[2]).
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Register reset values.
  localparam logic [8:0] RESET_ROWS = 9'd256;
  localparam logic [4:0] RESET_COLS = 5'd16;

  // Epoch tag stored beside each entry; tag zero never matches a live epoch.
  localparam int             EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic execute;
    logic sweep_wr;
  } egsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic item_clear;
    logic epoch_at_max;
    logic sweep_last;
  } egsa_stat_t;

endpackage

>>> sv/egsa_ctrl.sv
// Controller state machine: item sequencing and the store clearing sweep.
module egsa_ctrl
  import egsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  egsa_stat_t stat,
  output egsa_cmd_t  cmd
);

  localparam logic [1:0] ST_SWEEP  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_EXEC   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // State register; reset starts with a sweep that invalidates every entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.execute   = 1'b0;
    cmd.sweep_wr  = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          // The last epoch is used up; tags must be wiped before reuse.
          if (stat.item_clear && stat.epoch_at_max) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/egsa_datapath.sv
// Datapath: item registers, tagged gradient memory, saturating adder and output register.
module egsa_datapath
  import egsa_pkg::*;
#(
  parameter int ROWS = 256,
  parameter int DIM  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  egsa_cmd_t          cmd,
  output egsa_stat_t         stat,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_row_index,
  input  logic [3:0]         in_column,
  input  logic signed [31:0] in_grad_value,
  input  logic [8:0]         rows_in_use,
  input  logic [4:0]         columns_in_use,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [31:0]        read_value,
  output logic [1:0]         status
);

  localparam int ENTRIES = ROWS * DIM;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WORD_W  = EPOCH_W + 32;

  // Range checks and entry address of the incoming word.
  logic          row_bad_in;
  logic          col_bad_in;
  logic [AW-1:0] addr_in;

  assign row_bad_in = (in_row_index < 0)
                   || (in_row_index >= $signed({23'd0, rows_in_use}))
                   || (in_row_index >= ROWS);
  assign col_bad_in = ({1'b0, in_column} >= columns_in_use) || (int'(in_column) >= DIM);
  assign addr_in    = AW'(in_row_index[ROW_W-1:0]) * AW'(DIM) + AW'(in_column);

  // Item registers, loaded when the word is accepted.
  logic [1:0]    item_cmd;
  logic          item_row_bad;
  logic          item_col_bad;
  logic [AW-1:0] item_addr;
  logic [31:0]   item_grad;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd     <= in_command;
      item_row_bad <= row_bad_in;
      item_col_bad <= col_bad_in;
      item_addr    <= addr_in;
      item_grad    <= in_grad_value;
    end
  end

  // Current epoch and sweep counter.
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      sweep_cnt;
  logic               exec_clear;

  assign exec_clear = cmd.execute && (item_cmd == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= EPOCH_FIRST;
      sweep_cnt <= '0;
    end else begin
      if (exec_clear) begin
        epoch     <= (epoch == EPOCH_MAX) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
        sweep_cnt <= '0;
      end else if (cmd.sweep_wr) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
    end
  end

  // Tagged memory: each word is {epoch tag, Q16.16 sum}.
  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word;
  logic              do_write;
  logic [31:0]       sum_sat;

  assign mem_we  = cmd.sweep_wr || (cmd.execute && do_write);
  assign wr_addr = cmd.sweep_wr ? sweep_cnt : item_addr;
  assign wr_word = cmd.sweep_wr ? '0 : {epoch, sum_sat};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[item_addr];
  end

  // Saturating accumulate; an entry from an older epoch reads as zero.
  logic        entry_live;
  logic [31:0] old_val;
  logic [32:0] sum_wide;
  logic        sat;

  assign entry_live = (rd_word[WORD_W-1:32] == epoch);
  assign old_val    = entry_live ? rd_word[31:0] : 32'd0;
  assign sum_wide   = {old_val[31], old_val} + {item_grad[31], item_grad};
  assign sat        = sum_wide[32] ^ sum_wide[31];
  assign sum_sat    = sat ? (sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_wide[31:0];

  // Result of the item held in the registers.
  logic [31:0] res_value;
  logic [1:0]  res_status;

  always_comb begin
    do_write   = 1'b0;
    res_value  = 32'd0;
    res_status = STAT_OK;
    case (item_cmd) inside
      CMD_ACCUM, CMD_READ: begin
        if (item_row_bad) begin
          res_status = STAT_ROW;
        end else if (item_col_bad) begin
          res_status = STAT_COL;
        end else if (item_cmd == CMD_ACCUM) begin
          do_write   = 1'b1;
          res_status = sat ? STAT_SAT : STAT_OK;
        end else begin
          res_value = old_val;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // Output register; the next word may be accepted while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.execute) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

  assign stat.out_free     = !m_tvalid || m_tready;
  assign stat.item_clear   = (item_cmd == CMD_CLEAR);
  assign stat.epoch_at_max = (epoch == EPOCH_MAX);
  assign stat.sweep_last   = (sweep_cnt == AW'(ENTRIES - 1));

endmodule

>>> sv/embedding_gradient_scatter_add.sv
// Top level of the embedding gradient scatter-add: configuration registers and block wiring.
//
// Each input word is a command (clear, accumulate, read) and yields exactly one result word.
// A word passes three steps: accept, memory read, then add-and-write with the result loaded
// into the output register; the read step comes from the gradient memory's registered
// read, and the write step waits while an untaken result holds the output register. A result
// may wait in the output register while the next word is accepted. Clear is a single step
// that advances an 8-bit epoch tag kept beside every entry; after reset, and after every
// 255th clear, the block runs a sweep that wipes the tags of all ROWS*DIM entries (4096 at
// the default size); it takes no input word, though configuration writes still are.
module embedding_gradient_scatter_add
  import egsa_pkg::*;
#(
  parameter int ROWS = 256,
  parameter int DIM  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // row_index[31:0], column[35:32], grad_value[67:36], zero
  input  logic [1:0]  s_tuser,   // command[1:0]
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_value[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] rows_in_use;
  logic [4:0] columns_in_use;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= RESET_ROWS;
      columns_in_use <= RESET_COLS;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_in_use <= pwdata[8:0];
      end else begin
        columns_in_use <= pwdata[4:0];
      end
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = {23'd0, rows_in_use};
      REG_COLS: prdata = {27'd0, columns_in_use};
      default:  prdata = 32'd0;
    endcase
  end

  egsa_cmd_t  cmd;
  egsa_stat_t stat;

  egsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egsa_datapath #(
    .ROWS (ROWS),
    .DIM  (DIM)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (s_tuser),
    .in_row_index   (s_tdata[31:0]),
    .in_column      (s_tdata[35:32]),
    .in_grad_value  (s_tdata[67:36]),
    .rows_in_use    (rows_in_use),
    .columns_in_use (columns_in_use),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .read_value     (m_tdata),
    .status         (m_tuser)
  );

  // Only one word is in flight: an accepted word drops ready on the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is still being processed");

  // A flagged result never carries a value (non-read results are zero too, but only flagged statuses are checked).
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STAT_ROW || m_tuser == STAT_COL || m_tuser == STAT_SAT))
      |-> (m_tdata == 32'd0))
    else $error("flagged result carries a nonzero value");

  // A fresh result is raised by the execute step that follows its word's accept and memory read
  // steps, so each rise of the valid flag is checked against the acceptance of that word.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
    else $error("result appeared without a matching accepted word");

endmodule
